// ===== hdl/ilp_pkg.sv =====
// ----------------------------------------------------------------------------
// ilp_pkg
// Shared types, character codes and the digit decoder of the integer literal
// parser.
// ----------------------------------------------------------------------------
package ilp_pkg;

    localparam int VALUE_W  = 63;
    localparam int STATUS_W = 2;
    localparam int CHAR_W   = 8;
    localparam int DIGIT_W  = 6;

    // Character codes
    localparam logic [CHAR_W-1:0] CHAR_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UC_A       = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UC_Z       = 8'h5A;
    localparam logic [CHAR_W-1:0] CHAR_LC_A       = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LC_Z       = 8'h7A;
    localparam logic [CHAR_W-1:0] CHAR_UC_B       = 8'h42;
    localparam logic [CHAR_W-1:0] CHAR_LC_B       = 8'h62;
    localparam logic [CHAR_W-1:0] CHAR_UC_O       = 8'h4F;
    localparam logic [CHAR_W-1:0] CHAR_LC_O       = 8'h6F;
    localparam logic [CHAR_W-1:0] CHAR_UC_X       = 8'h58;
    localparam logic [CHAR_W-1:0] CHAR_LC_X       = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5F;

    localparam logic [DIGIT_W-1:0] LETTER_BASE = 6'd10;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_BIN = 2'd3
    } radix_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_TOO_BIG = 2'd2
    } status_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
    } result_t;

    typedef struct packed {
        logic               ok;
        logic [DIGIT_W-1:0] val;
    } digit_t;

    function automatic digit_t digit_of(input logic [CHAR_W-1:0] c);
        digit_t             d;
        logic [CHAR_W-1:0]  off_num;
        logic [CHAR_W-1:0]  off_lc;
        logic [CHAR_W-1:0]  off_uc;
        off_num = c - CHAR_ZERO;
        off_lc  = c - CHAR_LC_A;
        off_uc  = c - CHAR_UC_A;
        d.ok  = 1'b1;
        d.val = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d.val = off_num[DIGIT_W-1:0];
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
            d.val = off_lc[DIGIT_W-1:0] + LETTER_BASE;
        end else if (c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
            d.val = off_uc[DIGIT_W-1:0] + LETTER_BASE;
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== hdl/ilp_accum.sv =====
// ----------------------------------------------------------------------------
// ilp_accum
// Literal state registers and the per-character update: prefix detection,
// Horner step by shifts and adds, overflow and character checks.
// ----------------------------------------------------------------------------
module ilp_accum (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [ilp_pkg::CHAR_W-1:0]  character,
    input  logic                        last,
    output ilp_pkg::result_t            res
);
    import ilp_pkg::*;

    localparam int PROD_W = VALUE_W + 4;

    logic [VALUE_W-1:0] value_reg, value_next;
    radix_t             radix_reg, radix_next;
    logic [1:0]         pos_reg, pos_next;
    logic               fz_reg, fz_next;
    status_t            err_reg, err_next;

    logic [VALUE_W-1:0] value_proc;
    status_t            err_proc;
    logic               prefix;
    digit_t             digit;
    logic [PROD_W-1:0]  prod;
    logic               mul_ovf;
    logic [64:0]        sum;
    logic               sum_big;

    assign digit = digit_of(character);

    always_comb begin
        case (radix_reg)
            RADIX_HEX: prod = {value_reg, 4'b0};
            RADIX_OCT: prod = {1'b0, value_reg, 3'b0};
            RADIX_BIN: prod = {3'b0, value_reg, 1'b0};
            default:   prod = {3'b0, value_reg, 1'b0} + {1'b0, value_reg, 3'b0};
        endcase
    end

    assign mul_ovf = |prod[PROD_W-1:64];
    assign sum     = {1'b0, prod[63:0]} + {{(65-DIGIT_W){1'b0}}, digit.val};
    assign sum_big = |sum[64:63];

    always_comb begin
        value_next = value_reg;
        radix_next = radix_reg;
        pos_next   = pos_reg;
        fz_next    = fz_reg;
        err_next   = err_reg;
        value_proc = value_reg;
        err_proc   = err_reg;
        prefix     = 1'b0;

        if (pos_reg == 2'd1 && fz_reg && !last) begin
            if (character == CHAR_LC_X || character == CHAR_UC_X) begin
                radix_next = RADIX_HEX;
                prefix     = 1'b1;
            end else if (character == CHAR_LC_O || character == CHAR_UC_O) begin
                radix_next = RADIX_OCT;
                prefix     = 1'b1;
            end else if (character == CHAR_LC_B || character == CHAR_UC_B) begin
                radix_next = RADIX_BIN;
                prefix     = 1'b1;
            end
        end
        if (pos_reg == 2'd0) begin
            fz_next = (character == CHAR_ZERO);
        end

        // Overflow of the multiply wins over a bad character
        if (prefix) begin
            value_proc = '0;
        end else if (err_reg == ST_OK && character != CHAR_UNDERSCORE) begin
            if (mul_ovf) begin
                err_proc = ST_TOO_BIG;
            end else if (!digit.ok) begin
                err_proc = ST_INVALID;
            end else if (sum_big) begin
                err_proc = ST_TOO_BIG;
            end else begin
                value_proc = sum[VALUE_W-1:0];
            end
        end

        if (pos_reg != 2'd2) begin
            pos_next = pos_reg + 2'd1;
        end
        value_next = value_proc;
        err_next   = err_proc;

        // Clear for the next literal
        if (last) begin
            value_next = '0;
            radix_next = RADIX_DEC;
            pos_next   = 2'd0;
            fz_next    = 1'b0;
            err_next   = ST_OK;
        end

        res.value  = (err_proc == ST_OK) ? value_proc : '0;
        res.status = err_proc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
            radix_reg <= RADIX_DEC;
            pos_reg   <= 2'd0;
            fz_reg    <= 1'b0;
            err_reg   <= ST_OK;
        end else if (step) begin
            value_reg <= value_next;
            radix_reg <= radix_next;
            pos_reg   <= pos_next;
            fz_reg    <= fz_next;
            err_reg   <= err_next;
        end
    end

    a_radix_needs_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        radix_reg != RADIX_DEC |-> fz_reg && pos_reg == 2'd2)
        else $error("radix switched without a leading zero prefix");

    a_pos_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 2'd3)
        else $error("position counter passed saturation");

    a_error_freezes_value: assert property (@(posedge aclk) disable iff (!aresetn)
        step && !last && err_reg != ST_OK |=> value_reg == $past(value_reg))
        else $error("value moved after a sticky error");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && last |=> value_reg == '0 && err_reg == ST_OK && pos_reg == 2'd0)
        else $error("state not cleared after final character");

endmodule

// ===== hdl/integer_literal_parser.sv =====
// ----------------------------------------------------------------------------
// integer_literal_parser
// Parses a radix-prefixed integer literal, one character per item, and
// returns value and status on the final character.
// ----------------------------------------------------------------------------
//  Channel  Ports                              Moves
//  input    s_valid s_ready s_character s_last one character of the literal
//  result   m_valid m_ready m_value m_status   parsed value and status
//
//  One item is taken every cycle unless a held result stalls a final character;
//  the character passes an input register, the update logic and, on the final
//  character, the result register. A result is shown on m_valid the cycle after
//  its item left the input register; the state update is a shift-and-add times
//  the base, a digit add and a limit compare, all behind the input register.
//  aresetn (synchronous, active low) clears the literal state and both stages.
//  A held result stalls only a final character; other characters keep moving.
// ----------------------------------------------------------------------------
module integer_literal_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [ilp_pkg::CHAR_W-1:0]    s_character,
    input  logic                          s_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [ilp_pkg::VALUE_W-1:0]   m_value,
    output logic [ilp_pkg::STATUS_W-1:0]  m_status
);
    import ilp_pkg::*;

    logic               in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0]  in_char_reg;
    logic               in_last_reg;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;
    result_t            res;
    logic               process;
    logic               take;

    // Advance the held character unless it would produce a result with nowhere to go
    assign process = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || process;
    assign take    = s_valid && s_ready;

    always_comb begin
        if (take) begin
            in_valid_next = 1'b1;
        end else if (process) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (process && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    ilp_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (process),
        .character (in_char_reg),
        .last      (in_last_reg),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            in_char_reg <= s_character;
            in_last_reg <= s_last;
        end
        if (process && in_last_reg) begin
            out_reg <= res;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_value  = out_reg.value;
    assign m_status = out_reg.status;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for integer_literal_parser. A scoreboard class predicts the value
// and status of each literal from the characters accepted on the input
// channel. It compares them with the items on the result channel. Stimulus is
// a short directed set, then random literals: well-formed ones in all four
// bases, values around the 63-bit limit, noise and broken literals. Random
// idle bursts occur on both channels.
// ----------------------------------------------------------------------------
import ilp_pkg::*;

localparam logic [63:0] VALUE_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

function automatic int base_of(radix_t r);
    case (r)
        RADIX_HEX: return 16;
        RADIX_OCT: return 8;
        RADIX_BIN: return 2;
        default:   return 10;
    endcase
endfunction

class literal_checker;
    logic [63:0] acc;
    radix_t      radix;
    int          pos;
    logic        first_zero;
    status_t     err;
    result_t     results[$];
    int          failures;

    function new();
        clear();
        failures = 0;
    endfunction

    function void clear();
        acc        = '0;
        radix      = RADIX_DEC;
        pos        = 0;
        first_zero = 1'b0;
        err        = ST_OK;
    endfunction

    function int pending();
        return results.size();
    endfunction

    function void flag(string msg);
        failures++;
        if (failures <= 10) $display("%t: %s", $realtime, msg);
    endfunction

    function int char_digit(logic [7:0] c);
        if (c inside {[CHAR_ZERO:CHAR_NINE]}) return int'(c - CHAR_ZERO);
        if (c inside {[CHAR_LC_A:CHAR_LC_Z]}) return int'(c - CHAR_LC_A) + 10;
        if (c inside {[CHAR_UC_A:CHAR_UC_Z]}) return int'(c - CHAR_UC_A) + 10;
        return -1;
    endfunction

    // The multiply overflow wins over a bad character, then the add is checked.
    function void accumulate(logic [7:0] c);
        logic [67:0] prod;
        logic [67:0] sum;
        int          d;
        prod = 68'(acc) * 68'(base_of(radix));
        if (prod > 68'h0_FFFF_FFFF_FFFF_FFFF) begin
            err = ST_TOO_BIG;
            return;
        end
        d = char_digit(c);
        if (d < 0) begin
            err = ST_INVALID;
            return;
        end
        sum = prod + 68'(d);
        if (sum > 68'(VALUE_LIMIT)) err = ST_TOO_BIG;
        else acc = sum[63:0];
    endfunction

    function void note_char(logic [7:0] c, logic is_last);
        logic    prefix;
        result_t r;
        prefix = 1'b0;
        if (pos == 1 && first_zero && !is_last) begin
            if (c == CHAR_LC_X || c == CHAR_UC_X) begin
                radix  = RADIX_HEX;
                prefix = 1'b1;
            end else if (c == CHAR_LC_O || c == CHAR_UC_O) begin
                radix  = RADIX_OCT;
                prefix = 1'b1;
            end else if (c == CHAR_LC_B || c == CHAR_UC_B) begin
                radix  = RADIX_BIN;
                prefix = 1'b1;
            end
        end
        if (pos == 0) first_zero = (c == CHAR_ZERO);
        if (prefix) acc = '0;
        else if (err == ST_OK && c != CHAR_UNDERSCORE) accumulate(c);
        if (pos < 2) pos++;
        if (is_last) begin
            r.value  = (err == ST_OK) ? acc[62:0] : '0;
            r.status = err;
            results.push_back(r);
            clear();
        end
    endfunction

    function void check_result(logic [62:0] v, logic [1:0] s);
        result_t exp_r;
        if (results.size() == 0) begin
            flag($sformatf("unexpected result: value %h status %0d", v, s));
            return;
        end
        exp_r = results.pop_front();
        if (v !== exp_r.value)
            flag($sformatf("value mismatch: expected %h, got %h", exp_r.value, v));
        if (s !== exp_r.status)
            flag($sformatf("status mismatch: expected %0d, got %0d",
                           exp_r.status, s));
    endfunction
endclass

module tb;

    localparam int ITEM_GOAL      = 1750;
    localparam int WATCHDOG_LIMIT = 1000;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [CHAR_W-1:0]    s_character = '0;
    logic                 s_last      = 1'b0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [VALUE_W-1:0]   m_value;
    logic [STATUS_W-1:0]  m_status;

    literal_checker sb = new();
    logic [7:0]     lit[$];
    int             items_sent    = 0;
    int             literal_count = 0;
    int             idle_cycles   = 0;
    bit             idle_on       = 1'b1;

    integer_literal_parser dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_character (s_character),
        .s_last      (s_last),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_value     (m_value),
        .m_status    (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Note inputs before results: a result always trails its item.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_char(s_character, s_last);
            if (m_valid && m_ready) sb.check_result(m_value, m_status);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge aclk);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 6) == 0) begin
                stall = $urandom_range(1, 5) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic send_char(input logic [7:0] c, input logic is_last);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_character <= c;
        s_last      <= is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_literal();
        for (int i = 0; i < lit.size(); i++) send_char(lit[i], i == lit.size() - 1);
        literal_count++;
    endtask

    task automatic send_text(input string t);
        lit.delete();
        for (int i = 0; i < t.len(); i++) lit.push_back(t[i]);
        send_literal();
    endtask

    // Hold the input until every outstanding result has come out.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) return CHAR_ZERO + 8'(d);
        if ($urandom_range(0, 1) == 0) return CHAR_LC_A + 8'(d - 10);
        return CHAR_UC_A + 8'(d - 10);
    endfunction

    function automatic logic [7:0] bad_char();
        if ($urandom_range(0, 1) == 0) return 8'(8'h20 + $urandom_range(0, 15));
        return 8'($urandom_range(128, 255));
    endfunction

    task automatic push_prefix(input radix_t r);
        case (r)
            RADIX_HEX: begin
                lit.push_back(CHAR_ZERO);
                lit.push_back($urandom_range(0, 1) ? CHAR_LC_X : CHAR_UC_X);
            end
            RADIX_OCT: begin
                lit.push_back(CHAR_ZERO);
                lit.push_back($urandom_range(0, 1) ? CHAR_LC_O : CHAR_UC_O);
            end
            RADIX_BIN: begin
                lit.push_back(CHAR_ZERO);
                lit.push_back($urandom_range(0, 1) ? CHAR_LC_B : CHAR_UC_B);
            end
            default: ;
        endcase
    endtask

    task automatic build_wellformed();
        radix_t r;
        int     base;
        int     ndig;
        int     d;
        r    = radix_t'($urandom_range(0, 3));
        base = base_of(r);
        push_prefix(r);
        if ($urandom_range(0, 4) == 0) begin
            case (r)
                RADIX_HEX: ndig = $urandom_range(1, 18);
                RADIX_OCT: ndig = $urandom_range(1, 23);
                RADIX_BIN: ndig = $urandom_range(1, 66);
                default:   ndig = $urandom_range(1, 21);
            endcase
        end else begin
            ndig = $urandom_range(1, 6);
        end
        for (int i = 0; i < ndig; i++) begin
            if ($urandom_range(0, 7) == 0) lit.push_back(CHAR_UNDERSCORE);
            // digits are not range-checked against the base
            d = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 35)
                                             : $urandom_range(0, base - 1);
            lit.push_back(digit_char(d));
        end
    endtask

    // Encode a value near the 63-bit limit, or a random one, in a random base.
    task automatic build_boundary();
        radix_t      r;
        logic [63:0] v;
        logic [63:0] rest;
        int          base;
        int          digits[$];
        r    = radix_t'($urandom_range(0, 3));
        base = base_of(r);
        case ($urandom_range(0, 5))
            0: v = VALUE_LIMIT;
            1: v = VALUE_LIMIT + 64'd1;
            2: v = VALUE_LIMIT - 64'($urandom_range(0, 1000));
            3: v = '1;
            4: v = VALUE_LIMIT + 64'($urandom_range(1, 1000));
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        rest = v;
        do begin
            digits.push_front(int'(rest % 64'(base)));
            rest = rest / 64'(base);
        end while (rest != 0);
        push_prefix(r);
        foreach (digits[i]) begin
            if ($urandom_range(0, 9) == 0) lit.push_back(CHAR_UNDERSCORE);
            lit.push_back(digit_char(digits[i]));
        end
    endtask

    task automatic build_noise();
        int n;
        n = $urandom_range(1, 6);
        if ($urandom_range(0, 1) == 0) lit.push_back(CHAR_ZERO);
        for (int i = 0; i < n; i++) lit.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_broken();
        case ($urandom_range(0, 3))
            0: begin
                build_wellformed();
                lit.insert($urandom_range(0, lit.size()), bad_char());
            end
            1: begin
                // prefix letter as the final character stays decimal
                lit.push_back(CHAR_ZERO);
                case ($urandom_range(0, 5))
                    0: lit.push_back(CHAR_LC_X);
                    1: lit.push_back(CHAR_UC_X);
                    2: lit.push_back(CHAR_LC_O);
                    3: lit.push_back(CHAR_UC_O);
                    4: lit.push_back(CHAR_LC_B);
                    default: lit.push_back(CHAR_UC_B);
                endcase
            end
            2: begin
                build_boundary();
                lit.push_back(bad_char());
                lit.push_back(digit_char($urandom_range(0, 9)));
            end
            default: begin
                // underscore shifts the letter out of the prefix slot
                lit.push_back(CHAR_ZERO);
                lit.push_back(CHAR_UNDERSCORE);
                lit.push_back(CHAR_LC_X);
                lit.push_back(digit_char($urandom_range(0, 35)));
            end
        endcase
    endtask

    initial begin
        int kind;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_text("0");
        send_text("0x");
        send_text("0B");
        send_text("0o7");
        send_text("0X_fF");
        send_text("0b1z");
        send_text("1_$9");
        send_text("_");
        send_text("00x1");
        send_text("Z");
        lit.delete();
        lit.push_back(8'hFF);
        send_literal();

        while (items_sent < ITEM_GOAL) begin
            if (items_sent > ITEM_GOAL * 7 / 8) idle_on = 1'b0;
            if (literal_count % 40 == 39) drain_results();
            lit.delete();
            kind = $urandom_range(0, 99);
            if (kind < 60) build_wellformed();
            else if (kind < 72) build_boundary();
            else if (kind < 87) build_noise();
            else build_broken();
            send_literal();
        end

        drain_results();
        repeat (10) @(posedge aclk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/ilp_pkg.sv
hdl/ilp_accum.sv
hdl/integer_literal_parser.sv
tb/tb.sv
